// File: hw/rtl/wgb_pkg.sv
package wgb_pkg;

   localparam int DEF_NUM_WAVES  = 16;
   localparam int DEF_NUM_GROUPS = 16;
   localparam int DEF_MAX_NAMED  = 16;

   localparam int CNT_W   = 7;
   localparam int STATE_W = 27;
   localparam int MASK_W  = 16;

   localparam logic [3:0] OP_BEGIN  = 4'd0;
   localparam logic [3:0] OP_START  = 4'd1;
   localparam logic [3:0] OP_INIT   = 4'd2;
   localparam logic [3:0] OP_JOIN   = 4'd3;
   localparam logic [3:0] OP_SIGNAL = 4'd4;
   localparam logic [3:0] OP_WAIT   = 4'd5;
   localparam logic [3:0] OP_LEAVE  = 4'd6;
   localparam logic [3:0] OP_STATE  = 4'd7;
   localparam logic [3:0] OP_RETIRE = 4'd8;
   localparam logic [3:0] OP_ABORT  = 4'd9;

   localparam logic [1:0] WAIT_NONE  = 2'd0;
   localparam logic [1:0] WAIT_WG    = 2'd1;
   localparam logic [1:0] WAIT_TRAP  = 2'd2;
   localparam logic [1:0] WAIT_NAMED = 2'd3;

   localparam logic [5:0] ID_NONE = 6'b000000;
   localparam logic [5:0] ID_WG   = 6'b111111;
   localparam logic [5:0] ID_TRAP = 6'b111110;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } state_type;

endpackage

// File: hw/rtl/wgb_req_if.sv
interface wgb_req_if;
   import wgb_pkg::*;
   logic              valid;
   logic              ready;
   logic [3:0]        operation;
   logic [3:0]        wave_slot;
   logic [3:0]        group_slot;
   logic signed [5:0] barrier_sel;
   logic [6:0]        member_target;
   logic [4:0]        wave_count;
   logic [4:0]        named_count;
   logic              privileged;

   modport source (output valid, operation, wave_slot, group_slot, barrier_sel,
                   member_target, wave_count, named_count, privileged, input ready);
   modport sink (input valid, operation, wave_slot, group_slot, barrier_sel,
                 member_target, wave_count, named_count, privileged, output ready);
endinterface

// File: hw/rtl/wgb_rsp_if.sv
interface wgb_rsp_if;
   import wgb_pkg::*;
   logic               valid;
   logic               ready;
   logic               flag;
   logic [STATE_W-1:0] state_word;
   logic [MASK_W-1:0]  released_mask;
   logic               now_blocked;
   logic               group_done;

   modport source (output valid, flag, state_word, released_mask, now_blocked,
                   group_done, input ready);
   modport sink (input valid, flag, state_word, released_mask, now_blocked,
                 group_done, output ready);
endinterface

// File: hw/rtl/workgroup_barrier_unit.sv
// Workgroup barrier unit.
// req_chan carries one barrier operation per beat (begin, wave start, init,
// join, signal, wait, leave, state, retire, abort); rsp_chan returns exactly
// one result beat per request beat, in order.
// The barrier counters of each workgroup live in one row of a synchronous
// memory. The accept cycle reads the row, the next cycle modifies it, writes
// it back and updates the per-wave table in flip-flops, where a completing
// barrier is matched against all wave slots at once.
// The result beat is registered at the end of the row update.
// A new request is taken only after the row read-modify-write of the last one.
// The result waits in an output register; a new request is taken while it
// waits only if it is taken in the same cycle, so a stalled receiver holds
// off the request side after one beat.
// Reset (synchronous): all waves inactive, all workgroups invalid, no waits.
// Counter rows need no clearing: a row's counters are used only for a valid
// workgroup, and begin writes the whole row.
module workgroup_barrier_unit #(
   parameter int NUM_WAVES  = wgb_pkg::DEF_NUM_WAVES,
   parameter int NUM_GROUPS = wgb_pkg::DEF_NUM_GROUPS,
   parameter int MAX_NAMED  = wgb_pkg::DEF_MAX_NAMED
) (
   input logic clock,
   input logic reset,
   wgb_req_if.sink   req_chan,
   wgb_rsp_if.source rsp_chan
);
   import wgb_pkg::*;

   localparam int WIDX    = $clog2(NUM_WAVES);
   localparam int GIDX    = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
   localparam int CSTRIDE = MAX_NAMED + 3;
   localparam int KW      = $clog2(CSTRIDE);
   localparam int ROW_W   = 2 * CSTRIDE * CNT_W;

   typedef logic [CSTRIDE-1:0][CNT_W-1:0] cnt_row_type;

   state_type state_ff, state_in;

   logic [3:0]        op_ff;
   logic [3:0]        w_ff;
   logic [3:0]        gs_ff;
   logic [5:0]        id_ff;
   logic [6:0]        mc_ff;
   logic [4:0]        wc_ff;
   logic [4:0]        nc_ff;
   logic              priv_ff;

   logic              act_ff  [NUM_WAVES];
   logic [GIDX-1:0]   grp_ff  [NUM_WAVES];
   logic [4:0]        nid_ff  [NUM_WAVES];
   logic [2:0]        done_ff [NUM_WAVES];
   logic [1:0]        wait_ff [NUM_WAVES];
   logic              act_in  [NUM_WAVES];
   logic [GIDX-1:0]   grp_in  [NUM_WAVES];
   logic [4:0]        nid_in  [NUM_WAVES];
   logic [2:0]        done_in [NUM_WAVES];
   logic [1:0]        wait_in [NUM_WAVES];

   logic              gval_ff   [NUM_GROUPS];
   logic [4:0]        live_ff   [NUM_GROUPS];
   logic [4:0]        alloc_ff  [NUM_GROUPS];
   logic              gval_in   [NUM_GROUPS];
   logic [4:0]        live_in   [NUM_GROUPS];
   logic [4:0]        alloc_in  [NUM_GROUPS];

   logic               rsp_valid_ff;
   logic               flag_ff,  flag_in;
   logic [STATE_W-1:0] word_ff,  word_in;
   logic [MASK_W-1:0]  rel_ff,   rel_in;
   logic               blk_ff,   blk_in;
   logic               gdone_ff, gdone_in;

   logic              accept;
   logic              exec;
   logic [WIDX-1:0]   acc_w;
   logic [GIDX-1:0]   acc_grp;
   logic [GIDX-1:0]   row_grp;
   logic [ROW_W-1:0]  rd_row;
   logic [ROW_W-1:0]  wr_row;
   logic              wr_en;

   assign exec   = (state_ff == ST_EXEC);
   assign req_chan.ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_chan.ready);
   assign accept = req_chan.valid && req_chan.ready;

   always_comb begin
      acc_w = WIDX'(req_chan.wave_slot);
      if (req_chan.operation >= OP_INIT && req_chan.operation <= OP_STATE) begin
         acc_grp = grp_ff[acc_w];
      end else begin
         acc_grp = GIDX'(req_chan.group_slot);
      end
   end

   always_comb begin
      unique case (state_ff)
         ST_IDLE: state_in = accept ? ST_EXEC : ST_IDLE;
         ST_EXEC: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   wgb_row_mem #(
      .DEPTH(NUM_GROUPS),
      .WIDTH(ROW_W),
      .AW   (GIDX)
   ) u_rows (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(row_grp),
      .wr_data(wr_row),
      .rd_en  (accept),
      .rd_addr(acc_grp),
      .rd_data(rd_row)
   );

   always_comb begin
      logic [WIDX-1:0]   wi;
      logic [GIDX-1:0]   gsi;
      logic [GIDX-1:0]   gi;
      logic              ok;
      cnt_row_type       m;
      cnt_row_type       s;
      logic [KW-1:0]     k;
      logic [KW-1:0]     kn;
      logic [2:0]        cb;
      logic [4:0]        cnid;
      logic [CNT_W-1:0]  s1;
      logic [1:0]        code;
      logic [4:0]        alloc;
      logic              gv;
      logic              id_pos;
      logic              id_in;
      logic              lt_m2;
      logic              go;
      logic [2:0]        blocks;
      logic [4:0]        nid;

      wi  = WIDX'(w_ff);
      gsi = GIDX'(gs_ff);
      gi  = grp_ff[wi];
      {m, s} = rd_row;
      k    = '0;
      cb   = '0;
      cnid = '0;
      s1   = '0;
      code = WAIT_NONE;
      go   = 1'b0;
      nid  = nid_ff[wi];
      gv     = gval_ff[gi];
      alloc  = alloc_ff[gi];
      id_pos = !id_ff[5] && (id_ff != ID_NONE);
      id_in  = id_pos && (id_ff[4:0] <= alloc);
      lt_m2  = $signed(id_ff) < $signed(ID_TRAP);
      kn     = KW'(id_ff[4:0]) + KW'(2);
      blocks = 3'((6'(alloc) + 6'd3) >> 2);

      act_in  = act_ff;
      grp_in  = grp_ff;
      nid_in  = nid_ff;
      done_in = done_ff;
      wait_in = wait_ff;
      gval_in  = gval_ff;
      live_in  = live_ff;
      alloc_in = alloc_ff;
      wr_en    = 1'b0;
      flag_in  = 1'b0;
      word_in  = '0;
      rel_in   = '0;
      blk_in   = 1'b0;
      gdone_in = 1'b0;
      row_grp  = (op_ff >= OP_INIT && op_ff <= OP_STATE) ? gi : gsi;

      ok = (int'(w_ff) < NUM_WAVES) && (int'(gs_ff) < NUM_GROUPS);
      if (op_ff >= OP_INIT && op_ff <= OP_STATE && !act_ff[wi]) begin
         ok = 1'b0;
      end

      if (ok) begin
         unique case (op_ff)
            OP_BEGIN: begin
               live_in[gsi]  = wc_ff;
               gval_in[gsi]  = 1'b0;
               alloc_in[gsi] = '0;
               m = '0;
               s = '0;
               if (wc_ff > 5'd1) begin
                  gval_in[gsi]  = 1'b1;
                  alloc_in[gsi] = (int'(nc_ff) < MAX_NAMED) ? nc_ff : 5'(MAX_NAMED);
                  m[0] = 7'(wc_ff);
                  m[1] = 7'(wc_ff);
               end
               wr_en = 1'b1;
            end
            OP_START: begin
               if (!act_ff[wi]) begin
                  act_in[wi]  = 1'b1;
                  grp_in[wi]  = gsi;
                  nid_in[wi]  = '0;
                  done_in[wi] = '0;
                  wait_in[wi] = WAIT_NONE;
               end
            end
            OP_INIT: begin
               if (gv && id_in) begin
                  if (mc_ff != '0) begin
                     m[kn] = mc_ff;
                  end
                  s[kn] = '0;
                  wr_en = 1'b1;
               end
            end
            OP_JOIN: begin
               if (gv && (id_ff == ID_NONE || id_in)) begin
                  nid_in[wi]     = id_ff[4:0];
                  done_in[wi][2] = 1'b0;
                  if (wait_ff[wi] == WAIT_NAMED) begin
                     wait_in[wi] = WAIT_NONE;
                  end
               end
            end
            OP_SIGNAL: begin
               if (gv && id_ff != ID_NONE && !lt_m2) begin
                  if (id_pos) begin
                     if (id_in) begin
                        k = kn;
                        if (mc_ff != '0) begin
                           m[k] = mc_ff;
                        end
                        code = WAIT_NAMED;
                        cnid = id_ff[4:0];
                        go   = 1'b1;
                     end
                  end else if (id_ff == ID_WG) begin
                     k    = KW'(0);
                     code = WAIT_WG;
                     go   = 1'b1;
                  end else if (priv_ff) begin
                     k    = KW'(1);
                     code = WAIT_TRAP;
                     go   = 1'b1;
                  end
                  if (go) begin
                     wr_en = 1'b1;
                     if (m[k] != '0) begin
                        flag_in = (s[k] == '0);
                        s1 = (s[k] != 7'h7f) ? s[k] + 7'd1 : s[k];
                        if (s1 >= m[k]) begin
                           s[k] = '0;
                           unique case (code)
                              WAIT_WG:   cb[0] = 1'b1;
                              WAIT_TRAP: cb[1] = 1'b1;
                              default:   cb[2] = 1'b1;
                           endcase
                        end else begin
                           s[k] = s1;
                        end
                     end
                  end
               end
            end
            OP_WAIT: begin
               if (gv) begin
                  if (!id_ff[5]) begin
                     if (nid != '0 && nid <= alloc) begin
                        code = WAIT_NAMED;
                     end
                  end else if (!lt_m2 && (id_ff == ID_WG || priv_ff)) begin
                     code = (id_ff == ID_WG) ? WAIT_WG : WAIT_TRAP;
                  end
                  if (code != WAIT_NONE) begin
                     if (done_ff[wi][code-2'd1]) begin
                        done_in[wi][code-2'd1] = 1'b0;
                     end else begin
                        wait_in[wi] = code;
                        blk_in = 1'b1;
                     end
                  end
               end
            end
            OP_LEAVE: begin
               if (gv) begin
                  if (nid == '0) begin
                     flag_in = 1'b1;
                  end else if (nid <= alloc) begin
                     nid_in[wi]     = '0;
                     done_in[wi][2] = 1'b0;
                     if (wait_ff[wi] == WAIT_NAMED) begin
                        wait_in[wi] = WAIT_NONE;
                     end
                     k = KW'(nid) + KW'(2);
                     if (m[k] != '0) begin
                        m[k] = m[k] - 7'd1;
                     end
                     if (s[k] >= m[k]) begin
                        s[k]  = '0;
                        cb[2] = 1'b1;
                        cnid  = nid;
                     end
                     flag_in = (m[k] == '0);
                     wr_en = 1'b1;
                  end
               end
            end
            OP_STATE: begin
               if (gv && id_ff != ID_NONE && !lt_m2) begin
                  if (id_pos) begin
                     if (id_in) begin
                        k  = kn;
                        go = 1'b1;
                     end
                  end else if (id_ff == ID_WG) begin
                     k  = KW'(0);
                     go = 1'b1;
                  end else if (priv_ff) begin
                     k  = KW'(1);
                     go = 1'b1;
                  end
                  if (go) begin
                     word_in = {blocks, 1'b0, s[k], 5'b0, m[k], 3'b0, 1'b1};
                  end
               end
            end
            OP_RETIRE: begin
               if (act_ff[wi] && grp_ff[wi] == gsi) begin
                  act_in[wi]  = 1'b0;
                  nid_in[wi]  = '0;
                  done_in[wi] = '0;
                  wait_in[wi] = WAIT_NONE;
               end
               if (gval_ff[gsi]) begin
                  for (int kk = 0; kk < 2; kk++) begin
                     if (m[kk] != '0) begin
                        m[kk] = m[kk] - 7'd1;
                        if (m[kk] != '0 && s[kk] >= m[kk]) begin
                           s[kk]  = '0;
                           cb[kk] = 1'b1;
                        end
                     end
                  end
                  wr_en = 1'b1;
               end
               if (live_ff[gsi] != '0) begin
                  live_in[gsi] = live_ff[gsi] - 5'd1;
                  if (live_ff[gsi] == 5'd1) begin
                     gdone_in      = 1'b1;
                     gval_in[gsi]  = 1'b0;
                     alloc_in[gsi] = '0;
                  end
               end
            end
            OP_ABORT: begin
               for (int i = 0; i < NUM_WAVES; i++) begin
                  if (act_ff[i] && grp_ff[i] == gsi) begin
                     act_in[i]  = 1'b0;
                     nid_in[i]  = '0;
                     done_in[i] = '0;
                     wait_in[i] = WAIT_NONE;
                  end
               end
               live_in[gsi]  = '0;
               gval_in[gsi]  = 1'b0;
               alloc_in[gsi] = '0;
            end
            default: begin
            end
         endcase

         for (int i = 0; i < NUM_WAVES; i++) begin
            if (act_in[i] && grp_in[i] == row_grp) begin
               for (int c = 0; c < 3; c++) begin
                  if (cb[c] && (c != 2 || nid_in[i] == cnid)) begin
                     done_in[i][c] = 1'b1;
                     if (wait_in[i] == 2'(c + 1)) begin
                        done_in[i][c] = 1'b0;
                        wait_in[i]    = WAIT_NONE;
                        if (i < MASK_W) begin
                           rel_in[i] = 1'b1;
                        end
                     end
                  end
               end
            end
         end
      end

      wr_row = {m, s};
      wr_en  = wr_en && exec;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_WAVES; i++) begin
            act_ff[i]  <= 1'b0;
            nid_ff[i]  <= '0;
            done_ff[i] <= '0;
            wait_ff[i] <= WAIT_NONE;
         end
         for (int i = 0; i < NUM_GROUPS; i++) begin
            gval_ff[i]  <= 1'b0;
            live_ff[i]  <= '0;
            alloc_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (exec) begin
            rsp_valid_ff <= 1'b1;
            act_ff   <= act_in;
            nid_ff   <= nid_in;
            done_ff  <= done_in;
            wait_ff  <= wait_in;
            gval_ff  <= gval_in;
            live_ff  <= live_in;
            alloc_ff <= alloc_in;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff   <= req_chan.operation;
         w_ff    <= req_chan.wave_slot;
         gs_ff   <= req_chan.group_slot;
         id_ff   <= req_chan.barrier_sel;
         mc_ff   <= req_chan.member_target;
         wc_ff   <= req_chan.wave_count;
         nc_ff   <= req_chan.named_count;
         priv_ff <= req_chan.privileged;
      end
      if (exec) begin
         grp_ff   <= grp_in;
         flag_ff  <= flag_in;
         word_ff  <= word_in;
         rel_ff   <= rel_in;
         blk_ff   <= blk_in;
         gdone_ff <= gdone_in;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.flag          = flag_ff;
   assign rsp_chan.state_word    = word_ff;
   assign rsp_chan.released_mask = rel_ff;
   assign rsp_chan.now_blocked   = blk_ff;
   assign rsp_chan.group_done    = gdone_ff;

   a_no_accept_in_exec: assert property (@(posedge clock) disable iff (reset)
      exec |-> !req_chan.ready)
      else $error("request taken during row update");

   a_exec_gives_beat: assert property (@(posedge clock) disable iff (reset)
      exec |=> rsp_valid_ff)
      else $error("row update without result beat");

   a_release_source: assert property (@(posedge clock) disable iff (reset)
      (exec && rel_in != '0) |->
         (op_ff == OP_SIGNAL || op_ff == OP_LEAVE || op_ff == OP_RETIRE))
      else $error("wake from an operation that cannot complete a barrier");

endmodule

// File: hw/rtl/wgb_row_mem.sv
module wgb_row_mem #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 8,
   parameter int AW    = 4
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule
